### src/bcs1_pkg.sv
// Shared types and constants for the BLE channel selection (algorithm 1) block.
package bcs1_pkg;

	localparam int CH_W       = 6;
	localparam int HOP_W      = 5;
	localparam int MAP_W      = 37;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 37;
	localparam int ALU_W      = 7;

	localparam logic [ALU_W-1:0]     NUM_CH    = 7'd37;
	localparam logic [CH_W-1:0]      LAST_CH   = 6'd36;
	localparam logic [CH_W-1:0]      DIV_LAST  = 6'(CH_W - 1);
	localparam logic [HOP_W-1:0]     HOP_RESET = 5'd5;
	localparam logic [MAP_W-1:0]     MAP_RESET = {MAP_W{1'b1}};

	localparam logic [CFG_IDX_W-1:0] REG_HOP = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAP = 1'd1;

	typedef struct packed {
		logic [HOP_W-1:0] hop;
		logic [MAP_W-1:0] chmap;
	} cfg_t;

	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	typedef struct packed {
		logic [ALU_W-1:0] res;
		logic             borrow;
	} alu_out_t;

endpackage

### src/bcs1_if.sv
// Handshake interfaces for connection-event ticks and channel results.
interface bcs1_tick_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

interface bcs1_res_if;
	logic       valid;
	logic       ready;
	logic [5:0] channel;
	logic [5:0] unmapped_channel;
	logic       was_remapped;
	logic       map_empty;

	modport source (output valid, output channel, output unmapped_channel,
		output was_remapped, output map_empty, input ready);
	modport sink (input valid, input channel, input unmapped_channel,
		input was_remapped, input map_empty, output ready);
endinterface

### src/bcs1_regs.sv
// Configuration registers: hop increment and channel map.
module bcs1_regs import bcs1_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	logic [HOP_W-1:0] hop_q;
	logic [MAP_W-1:0] map_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hop_q <= HOP_RESET;
			map_q <= MAP_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_HOP: hop_q <= cfg_data[HOP_W-1:0];
				REG_MAP: map_q <= cfg_data[MAP_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.hop   = hop_q;
	assign cfg.chmap = map_q;

endmodule

### src/bcs1_alu.sv
// Shared 7-bit add/subtract unit with borrow out.
module bcs1_alu import bcs1_pkg::*; (
	input  alu_op_t          op,
	input  logic [ALU_W-1:0] a,
	input  logic [ALU_W-1:0] b,
	output alu_out_t         y
);

	logic [ALU_W:0] full;

	always_comb begin
		case (op)
			ALU_ADD: full = {1'b0, a} + {1'b0, b};
			ALU_SUB: full = {1'b0, a} - {1'b0, b};
			default: full = '0;
		endcase
		y.res    = full[ALU_W-1:0];
		y.borrow = full[ALU_W];
	end

endmodule

### src/bcs1_core.sv
// Sequencer: hop, map check, used-channel count, modulo and set-bit search.
module bcs1_core import bcs1_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	bcs1_tick_if.sink   tick,
	bcs1_res_if.source  res
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADD,
		S_WRAP,
		S_CHECK,
		S_COUNT,
		S_DIV,
		S_SEL,
		S_DONE
	} state_t;

	state_t            state_q;
	logic [CH_W-1:0]   last_q;
	logic [ALU_W-1:0]  acc_q;
	logic [CH_W-1:0]   cnt_q;
	logic [CH_W-1:0]   idx_q;
	logic [CH_W-1:0]   rem_q;
	logic [CH_W-1:0]   dvd_q;
	logic [CH_W-1:0]   seen_q;
	logic [CH_W-1:0]   chan_q;
	logic              remap_q;
	logic              empty_q;
	logic              out_valid_q;
	logic [CH_W-1:0]   out_chan_q;
	logic [CH_W-1:0]   out_unmap_q;
	logic              out_remap_q;
	logic              out_empty_q;

	alu_op_t           alu_op;
	logic [ALU_W-1:0]  alu_a;
	logic [ALU_W-1:0]  alu_b;
	alu_out_t          alu_y;
	logic              map_bit;
	logic [CH_W-1:0]   wrapped;

	assign map_bit = cfg.chmap[idx_q];
	assign wrapped = alu_y.borrow ? acc_q[CH_W-1:0] : alu_y.res[CH_W-1:0];

	always_comb begin
		alu_op = ALU_ADD;
		alu_a  = '0;
		alu_b  = '0;
		case (state_q)
			S_ADD: begin
				alu_a = acc_q;
				alu_b = {2'b00, cfg.hop};
			end
			S_WRAP: begin
				alu_op = ALU_SUB;
				alu_a  = acc_q;
				alu_b  = NUM_CH;
			end
			S_COUNT: begin
				alu_a = {1'b0, cnt_q};
				alu_b = {6'b0, map_bit};
			end
			S_DIV: begin
				alu_op = ALU_SUB;
				alu_a  = {rem_q, dvd_q[CH_W-1]};
				alu_b  = {1'b0, cnt_q};
			end
			S_SEL: begin
				alu_a = {1'b0, seen_q};
				alu_b = {6'b0, map_bit};
			end
			default: ;
		endcase
	end

	bcs1_alu u_alu (
		.op (alu_op),
		.a  (alu_a),
		.b  (alu_b),
		.y  (alu_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			last_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && res.ready && state_q != S_DONE)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (tick.valid) begin
						acc_q   <= tick.restart ? '0 : {1'b0, last_q};
						state_q <= S_ADD;
					end
				end
				S_ADD: begin
					acc_q   <= alu_y.res;
					state_q <= S_WRAP;
				end
				S_WRAP: begin
					acc_q   <= {1'b0, wrapped};
					last_q  <= wrapped;
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					empty_q <= 1'b0;
					idx_q   <= '0;
					cnt_q   <= '0;
					if (cfg.chmap[acc_q[CH_W-1:0]]) begin
						chan_q  <= acc_q[CH_W-1:0];
						remap_q <= 1'b0;
						state_q <= S_DONE;
					end else begin
						remap_q <= 1'b1;
						state_q <= S_COUNT;
					end
				end
				S_COUNT: begin
					cnt_q <= alu_y.res[CH_W-1:0];
					if (idx_q == LAST_CH) begin
						idx_q <= '0;
						rem_q <= '0;
						dvd_q <= acc_q[CH_W-1:0];
						if (alu_y.res[CH_W-1:0] == '0) begin
							empty_q <= 1'b1;
							chan_q  <= '0;
							state_q <= S_DONE;
						end else begin
							state_q <= S_DIV;
						end
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_DIV: begin
					// restoring division, one quotient bit per cycle
					rem_q <= alu_y.borrow ? alu_a[CH_W-1:0] : alu_y.res[CH_W-1:0];
					dvd_q <= {dvd_q[CH_W-2:0], 1'b0};
					if (idx_q == DIV_LAST) begin
						idx_q   <= '0;
						seen_q  <= '0;
						state_q <= S_SEL;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_SEL: begin
					if (map_bit && seen_q == rem_q) begin
						chan_q  <= idx_q;
						state_q <= S_DONE;
					end else begin
						seen_q <= alu_y.res[CH_W-1:0];
						idx_q  <= idx_q + 1'b1;
					end
				end
				S_DONE: begin
					if (!out_valid_q || res.ready) begin
						out_valid_q <= 1'b1;
						out_chan_q  <= chan_q;
						out_unmap_q <= acc_q[CH_W-1:0];
						out_remap_q <= remap_q;
						out_empty_q <= empty_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign tick.ready           = (state_q == S_IDLE);
	assign res.valid            = out_valid_q;
	assign res.channel          = out_chan_q;
	assign res.unmapped_channel = out_unmap_q;
	assign res.was_remapped     = out_remap_q;
	assign res.map_empty        = out_empty_q;

endmodule

### src/ble_channel_select_csa1_top.sv
// Top level of the BLE data channel selector, algorithm 1.
//
// One transaction on tick is one connection event; restart clears the hop
// sequence before that event's hop. Each tick gives exactly one transaction
// on res: selected channel, unmapped channel and remap / empty-map flags.
// Registers are written through cfg_we / cfg_idx / cfg_data: index 0 holds
// the hop increment, index 1 the 37-bit channel map.
//
// After a tick is taken the sequencer adds the hop, wraps it at 37 and checks
// the map: if the unmapped channel is used, it is the result. Otherwise it
// counts the used channels, stops there when the map is empty, and else runs
// a restoring modulo and a set-bit scan, all on one shared adder.
// tick.ready is high only while the sequencer is idle, so a new event is not
// taken until the sequencer has finished the last one.
// res is registered: a new tick is taken while a result waits, and the
// sequencer holds its finished result until the output register is free.
// Reset restores hop increment 5, all channels used and unmapped channel 0.
module ble_channel_select_csa1_top import bcs1_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	bcs1_tick_if.sink             tick,
	bcs1_res_if.source            res
);

	cfg_t cfg;

	bcs1_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	bcs1_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.tick   (tick),
		.res    (res)
	);

endmodule

### src/bcs1_checker.sv
// Port-level assertions for the channel selector, bound to the top level.
module bcs1_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic [5:0] res_channel,
	input logic [5:0] res_unmapped,
	input logic       res_remapped,
	input logic       res_empty
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_channel))
		else $error("result transaction dropped or changed while stalled");

	a_chan_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_channel <= 6'd36 && res_unmapped <= 6'd36)
		else $error("channel out of range");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_empty |-> res_channel == 6'd0 && res_remapped)
		else $error("empty map result malformed");

	a_direct: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_remapped |-> res_channel == res_unmapped && !res_empty)
		else $error("unremapped channel differs from unmapped channel");

endmodule

bind ble_channel_select_csa1_top bcs1_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (res.valid),
	.res_ready    (res.ready),
	.res_channel  (res.channel),
	.res_unmapped (res.unmapped_channel),
	.res_remapped (res.was_remapped),
	.res_empty    (res.map_empty)
);

### sim/ble_channel_select_csa1_top_tb.sv
// Self-checking testbench for the BLE channel selector, algorithm 1.
module ble_channel_select_csa1_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bcs1_pkg::*;

	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_TAIL  = 100;
	localparam int PHASES      = 26;
	localparam int PHASE_ITEMS = 50;

	typedef struct packed {
		logic [CH_W-1:0] channel;
		logic [CH_W-1:0] unmapped;
		logic            remapped;
		logic            empty;
	} hop_pick_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	bcs1_tick_if tick_ch();
	bcs1_res_if  res_ch();

	// shadow of the block's registers and hop state
	logic [HOP_W-1:0] hop_reg;
	logic [MAP_W-1:0] map_reg;
	logic [CH_W-1:0]  last_hop_ch;

	hop_pick_t pending_picks[$];
	int        fails;
	bit        steady;
	bit        hold_sink;

	ble_channel_select_csa1_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_idx (cfg_idx),
		.cfg_data(cfg_data),
		.tick    (tick_ch),
		.res     (res_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	// hop, then pick the channel; an unused hop is folded onto the used set
	function automatic hop_pick_t select_channel(input logic rst);
		hop_pick_t   p;
		int unsigned base;
		int unsigned used;
		int unsigned target;
		int unsigned seen;
		base = rst ? 0 : last_hop_ch;
		p.unmapped = CH_W'((base % MAP_W + hop_reg) % MAP_W);
		last_hop_ch = p.unmapped;
		used = $countones(map_reg);
		p.channel = '0;
		p.remapped = 1'b0;
		p.empty = 1'b0;
		if (map_reg[p.unmapped]) begin
			p.channel = p.unmapped;
		end else begin
			p.remapped = 1'b1;
			if (used == 0) begin
				p.empty = 1'b1;
			end else begin
				target = p.unmapped % used;
				seen = 0;
				for (int i = 0; i < MAP_W; i++) begin
					if (map_reg[i]) begin
						if (seen == target) begin
							p.channel = CH_W'(i);
							break;
						end
						seen++;
					end
				end
			end
		end
		return p;
	endfunction

	function automatic logic [MAP_W-1:0] random_map();
		logic [MAP_W-1:0] m;
		case ($urandom_range(9))
			0: m = '1;
			1: m = '0;
			2, 3: begin
				m = '0;
				repeat ($urandom_range(1, 4)) m[$urandom_range(MAP_W-1)] = 1'b1;
			end
			4: begin
				m = '1;
				repeat ($urandom_range(1, 6)) m[$urandom_range(MAP_W-1)] = 1'b0;
			end
			default: m = MAP_W'({$urandom, $urandom});
		endcase
		return m;
	endfunction

	function automatic logic [HOP_W-1:0] random_hop();
		if ($urandom_range(3) == 0)
			return HOP_W'($urandom_range(31));
		return HOP_W'($urandom_range(5, 16));
	endfunction

	// block must be idle here; valid is already low
	task automatic program_regs(input logic [HOP_W-1:0] hop, input logic [MAP_W-1:0] chmap);
		cfg_we <= 1'b1;
		cfg_idx <= REG_HOP;
		cfg_data <= CFG_DATA_W'(hop);
		@(posedge clk);
		cfg_idx <= REG_MAP;
		cfg_data <= CFG_DATA_W'(chmap);
		@(posedge clk);
		cfg_we <= 1'b0;
		hop_reg = hop;
		map_reg = chmap;
	endtask

	// returns at the edge where the event transaction is taken; valid stays up
	task automatic send_event(input logic rst);
		if (!steady) begin
			while ($urandom_range(99) < 36) begin
				tick_ch.valid <= 1'b0;
				@(posedge clk);
			end
		end
		tick_ch.valid <= 1'b1;
		tick_ch.restart <= rst;
		do @(posedge clk); while (!tick_ch.ready);
		pending_picks.push_back(select_channel(rst));
	endtask

	task automatic settle();
		tick_ch.valid <= 1'b0;
		while (pending_picks.size() != 0) @(posedge clk);
		repeat (DRAIN_TAIL) @(posedge clk);
	endtask

	task automatic test_reset_state();
		send_event(1'b0);
		send_event(1'b0);
		send_event(1'b1);
		settle();
	endtask

	task automatic test_corner_settings();
		// empty map, widest hop
		program_regs(5'd31, '0);
		send_event(1'b1);
		send_event(1'b0);
		send_event(1'b0);
		settle();
		// only the top channel used
		program_regs(5'd16, MAP_W'(1) << (MAP_W-1));
		send_event(1'b0);
		send_event(1'b1);
		send_event(1'b0);
		settle();
		// zero hop outside the usual range: sequence stands still on channel 0
		program_regs(5'd0, MAP_W'(1));
		send_event(1'b1);
		send_event(1'b0);
		settle();
		// hop onto channel 36 with it unused
		program_regs(5'd12, {1'b0, {(MAP_W-1){1'b1}}});
		send_event(1'b1);
		send_event(1'b0);
		send_event(1'b0);
		settle();
		program_regs(5'd7, MAP_W'(37'h0AAAAAAAAA));
		send_event(1'b1);
		send_event(1'b0);
		send_event(1'b0);
		send_event(1'b0);
		settle();
	endtask

	task automatic test_random_hopping();
		for (int ph = 0; ph < PHASES; ph++) begin
			steady = (ph == 3);
			program_regs(random_hop(), random_map());
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_event($urandom_range(19) == 0);
			settle();
		end
		steady = 1'b0;
	endtask

	// sink held off while the source keeps offering, so the input stalls
	task automatic test_backpressure();
		program_regs(random_hop(), random_map());
		steady = 1'b1;
		hold_sink = 1'b1;
		for (int n = 0; n < 12; n++)
			send_event($urandom_range(9) == 0);
		settle();
		steady = 1'b0;
	endtask

	task automatic test_source_pause();
		program_regs(5'd16, '1);
		for (int n = 0; n < 20; n++)
			send_event(n == 0);
		settle();
		for (int n = 0; n < 20; n++)
			send_event($urandom_range(9) == 0);
		settle();
	endtask

	initial begin
		fails = 0;
		steady = 1'b0;
		hold_sink = 1'b0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_idx <= REG_HOP;
		cfg_data <= '0;
		tick_ch.valid <= 1'b0;
		tick_ch.restart <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		hop_reg = HOP_RESET;
		map_reg = MAP_RESET;
		last_hop_ch = '0;
		@(posedge clk);

		test_reset_state();
		test_corner_settings();
		test_random_hopping();
		test_backpressure();
		test_source_pause();

		if (pending_picks.size() != 0) begin
			$error("%0d channel results never arrived", pending_picks.size());
			fails++;
		end
		if (fails == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : sink_side
		int held;
		held = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_sink && held < HOLD_CYCLES) begin
				res_ch.ready <= 1'b0;
				held++;
			end else begin
				res_ch.ready <= steady || ($urandom_range(99) >= 36);
			end
		end
	end

	always @(posedge clk) begin : res_check
		hop_pick_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_picks.size() == 0) begin
				$error("channel transaction with nothing outstanding: channel %0d",
					res_ch.channel);
				fails++;
			end else begin
				want = pending_picks.pop_front();
				if (res_ch.channel !== want.channel) begin
					$error("channel: expected %0d, got %0d", want.channel, res_ch.channel);
					fails++;
				end
				if (res_ch.unmapped_channel !== want.unmapped) begin
					$error("unmapped_channel: expected %0d, got %0d", want.unmapped,
						res_ch.unmapped_channel);
					fails++;
				end
				if (res_ch.was_remapped !== want.remapped) begin
					$error("was_remapped: expected %0b, got %0b", want.remapped,
						res_ch.was_remapped);
					fails++;
				end
				if (res_ch.map_empty !== want.empty) begin
					$error("map_empty: expected %0b, got %0b", want.empty, res_ch.map_empty);
					fails++;
				end
			end
		end
	end

endmodule
